[src/ecc_pkg.sv]
// ----------------------------------------------------------------------------
// ecc_pkg: shared types and constants of the elevator car controller
// Mode codes, register map, datapath command codes and the command and
// status structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ecc_pkg;

    // Floor count default for the top level
    localparam int FLOORS_DEFAULT = 8;

    // Fixed field widths
    localparam int FLOOR_W = 3;
    localparam int MODE_W  = 3;
    localparam int DIR_W   = 2;
    localparam int DUTY_W  = 7;
    localparam int COUNT_W = 8;
    localparam int MASK_W  = 8;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (byte address 4 * index)
    localparam logic [1:0] REG_DUTY_FULL  = 2'd0;
    localparam logic [1:0] REG_DUTY_SLOW  = 2'd1;
    localparam logic [1:0] REG_DUTY_STOP  = 2'd2;
    localparam logic [1:0] REG_DOOR_TICKS = 2'd3;

    // Register reset values
    localparam logic [DUTY_W-1:0]  DUTY_FULL_RESET  = 7'd100;
    localparam logic [DUTY_W-1:0]  DUTY_SLOW_RESET  = 7'd50;
    localparam logic [DUTY_W-1:0]  DUTY_STOP_RESET  = 7'd0;
    localparam logic [COUNT_W-1:0] DOOR_TICKS_RESET = 8'd6;

    // Door counter saturation value
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    // Car modes
    localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DOWN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DOORS = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EMERG = 3'd4;

    // Travel directions
    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DN   = 2'd2;

    // Duty selection
    localparam logic [1:0] DUTY_SEL_STOP = 2'd0;
    localparam logic [1:0] DUTY_SEL_SLOW = 2'd1;
    localparam logic [1:0] DUTY_SEL_FULL = 2'd2;

    // Destination update
    localparam logic [1:0] DEST_HOLD = 2'd0;
    localparam logic [1:0] DEST_UP   = 2'd1;
    localparam logic [1:0] DEST_DOWN = 2'd2;

    // Request vector update
    localparam logic [1:0] REQ_KEEP      = 2'd0;
    localparam logic [1:0] REQ_CLEAR_ALL = 2'd1;
    localparam logic [1:0] REQ_CLEAR_CAR = 2'd2;

    // Door flag update
    localparam logic [1:0] DOOR_HOLD  = 2'd0;
    localparam logic [1:0] DOOR_SET   = 2'd1;
    localparam logic [1:0] DOOR_CLOSE = 2'd2;

    // Door counter update
    localparam logic [1:0] CNT_HOLD  = 2'd0;
    localparam logic [1:0] CNT_CLEAR = 2'd1;
    localparam logic [1:0] CNT_COUNT = 2'd2;

    // Configuration register set
    typedef struct packed {
        logic [DUTY_W-1:0]  duty_full;
        logic [DUTY_W-1:0]  duty_slow;
        logic [DUTY_W-1:0]  duty_stop;
        logic [COUNT_W-1:0] door_ticks;
    } cfg_t;

    // Controller to datapath commands for one step
    typedef struct packed {
        logic [1:0]       duty_sel;
        logic             dir_load;
        logic [DIR_W-1:0] dir_val;
        logic [1:0]       dest_op;
        logic [1:0]       req_op;
        logic [1:0]       door_op;
        logic [1:0]       cnt_op;
        logic             tick_clr;
    } cmd_t;

    // Datapath to controller status, after the step's events are latched
    typedef struct packed {
        logic estop;
        logic found_up;
        logic found_down;
        logic near_up;
        logic near_down;
        logic at_target;
        logic door_done;
    } status_t;

endpackage

`default_nettype wire

[src/ecc_regs.sv]
// ----------------------------------------------------------------------------
// ecc_regs: configuration register file
// Four duty and door-timing registers on an APB-style port, zero wait states.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ecc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ecc_pkg::DATA_W-1:0]  pwdata,
    output logic      [ecc_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output ecc_pkg::cfg_t                    cfg
);

    ecc_pkg::cfg_t cfg_reg;
    ecc_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // Decode the write request
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                ecc_pkg::REG_DUTY_FULL:  cfg_next.duty_full  = pwdata[ecc_pkg::DUTY_W-1:0];
                ecc_pkg::REG_DUTY_SLOW:  cfg_next.duty_slow  = pwdata[ecc_pkg::DUTY_W-1:0];
                ecc_pkg::REG_DUTY_STOP:  cfg_next.duty_stop  = pwdata[ecc_pkg::DUTY_W-1:0];
                ecc_pkg::REG_DOOR_TICKS: cfg_next.door_ticks = pwdata[ecc_pkg::COUNT_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.duty_full  <= ecc_pkg::DUTY_FULL_RESET;
            cfg_reg.duty_slow  <= ecc_pkg::DUTY_SLOW_RESET;
            cfg_reg.duty_stop  <= ecc_pkg::DUTY_STOP_RESET;
            cfg_reg.door_ticks <= ecc_pkg::DOOR_TICKS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register
    always_comb begin
        unique case (reg_idx)
            ecc_pkg::REG_DUTY_FULL:  prdata = ecc_pkg::DATA_W'(cfg_reg.duty_full);
            ecc_pkg::REG_DUTY_SLOW:  prdata = ecc_pkg::DATA_W'(cfg_reg.duty_slow);
            ecc_pkg::REG_DUTY_STOP:  prdata = ecc_pkg::DATA_W'(cfg_reg.duty_stop);
            ecc_pkg::REG_DOOR_TICKS: prdata = ecc_pkg::DATA_W'(cfg_reg.door_ticks);
            default:                 prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[src/ecc_ctrl.sv]
// ----------------------------------------------------------------------------
// ecc_ctrl: car mode state machine
// Holds the car mode and issues the datapath commands for each update step.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       step,
    input  wire ecc_pkg::status_t           status,
    output ecc_pkg::cmd_t                   cmd,
    output logic      [ecc_pkg::MODE_W-1:0] mode
);

    logic [ecc_pkg::MODE_W-1:0] mode_reg;
    logic [ecc_pkg::MODE_W-1:0] mode_next;
    logic [ecc_pkg::MODE_W-1:0] mode_step;

    // Work out the commands and next mode for this step
    always_comb begin
        mode_step     = mode_reg;
        cmd.duty_sel  = ecc_pkg::DUTY_SEL_STOP;
        cmd.dir_load  = 1'b0;
        cmd.dir_val   = ecc_pkg::DIR_NONE;
        cmd.dest_op   = ecc_pkg::DEST_HOLD;
        cmd.req_op    = ecc_pkg::REQ_KEEP;
        cmd.door_op   = ecc_pkg::DOOR_HOLD;
        cmd.cnt_op    = ecc_pkg::CNT_HOLD;
        cmd.tick_clr  = 1'b0;
        if (status.estop) begin
            // Emergency latch overrides every mode
            mode_step    = ecc_pkg::MODE_EMERG;
            cmd.dir_load = 1'b1;
            cmd.door_op  = ecc_pkg::DOOR_CLOSE;
            cmd.cnt_op   = ecc_pkg::CNT_CLEAR;
            cmd.req_op   = ecc_pkg::REQ_CLEAR_ALL;
        end else begin
            unique case (mode_reg)
                ecc_pkg::MODE_IDLE: begin
                    cmd.dir_load = 1'b1;
                    if (status.found_up) begin
                        mode_step    = ecc_pkg::MODE_UP;
                        cmd.dir_val  = ecc_pkg::DIR_UP;
                        cmd.dest_op  = ecc_pkg::DEST_UP;
                        cmd.duty_sel = ecc_pkg::DUTY_SEL_FULL;
                    end else if (status.found_down) begin
                        mode_step    = ecc_pkg::MODE_DOWN;
                        cmd.dir_val  = ecc_pkg::DIR_DN;
                        cmd.dest_op  = ecc_pkg::DEST_DOWN;
                        cmd.duty_sel = ecc_pkg::DUTY_SEL_FULL;
                    end
                end
                ecc_pkg::MODE_UP, ecc_pkg::MODE_DOWN: begin
                    if ((mode_reg == ecc_pkg::MODE_UP) ? status.near_up : status.near_down) begin
                        cmd.duty_sel = ecc_pkg::DUTY_SEL_SLOW;
                    end else begin
                        cmd.duty_sel = ecc_pkg::DUTY_SEL_FULL;
                    end
                    // Stop at the target and open the doors
                    if (status.at_target) begin
                        mode_step    = ecc_pkg::MODE_DOORS;
                        cmd.duty_sel = ecc_pkg::DUTY_SEL_STOP;
                        cmd.req_op   = ecc_pkg::REQ_CLEAR_CAR;
                        cmd.door_op  = ecc_pkg::DOOR_SET;
                        cmd.cnt_op   = ecc_pkg::CNT_CLEAR;
                    end
                end
                ecc_pkg::MODE_DOORS: begin
                    cmd.tick_clr = 1'b1;
                    cmd.cnt_op   = ecc_pkg::CNT_COUNT;
                    if (status.door_done) begin
                        mode_step    = ecc_pkg::MODE_IDLE;
                        cmd.door_op  = ecc_pkg::DOOR_CLOSE;
                        cmd.dir_load = 1'b1;
                        cmd.cnt_op   = ecc_pkg::CNT_CLEAR;
                    end
                end
                ecc_pkg::MODE_EMERG: begin
                    mode_step = ecc_pkg::MODE_EMERG;
                end
                default: begin
                    // Unused code: drop back to idle
                    mode_step = ecc_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    assign mode_next = step ? mode_step : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ecc_pkg::MODE_IDLE;
        end else begin
            mode_reg <= mode_next;
        end
    end

    assign mode = mode_reg;

endmodule

`default_nettype wire

[src/ecc_dpath.sv]
// ----------------------------------------------------------------------------
// ecc_dpath: car datapath
// Latches the step's events, searches the request vector and holds position,
// destination, direction, duty, door flag, door counter and requests.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_dpath #(
    parameter int FLOORS = ecc_pkg::FLOORS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire logic                          sensor_valid,
    input  wire logic [ecc_pkg::FLOOR_W-1:0]   sensor_floor,
    input  wire logic                          call_valid,
    input  wire logic [ecc_pkg::FLOOR_W-1:0]   call_floor,
    input  wire logic                          estop,
    input  wire logic                          half_second_tick,
    input  wire ecc_pkg::cfg_t                 cfg,
    input  wire ecc_pkg::cmd_t                 cmd,
    output ecc_pkg::status_t                   status,
    output logic      [ecc_pkg::DIR_W-1:0]     direction,
    output logic      [ecc_pkg::DUTY_W-1:0]    duty,
    output logic                               doors_open,
    output logic      [ecc_pkg::FLOOR_W-1:0]   target_floor,
    output logic      [ecc_pkg::FLOOR_W-1:0]   cabin_floor,
    output logic      [ecc_pkg::MASK_W-1:0]    pending_mask
);

    // Only floors the 3-bit call field can name ever hold a request
    localparam int REQ_W = (FLOORS < (1 << ecc_pkg::FLOOR_W)) ? FLOORS
                                                               : (1 << ecc_pkg::FLOOR_W);

    logic [ecc_pkg::FLOOR_W-1:0] pos_reg,   pos_next,   pos_now;
    logic [ecc_pkg::FLOOR_W-1:0] dest_reg,  dest_next;
    logic [ecc_pkg::DIR_W-1:0]   dir_reg,   dir_next;
    logic [ecc_pkg::DUTY_W-1:0]  duty_reg,  duty_next;
    logic                        door_reg,  door_next;
    logic                        estop_reg, estop_next;
    logic                        tick_reg,  tick_next;
    logic [ecc_pkg::COUNT_W-1:0] cnt_reg,   cnt_next,   cnt_now;
    logic [REQ_W-1:0]            req_reg,   req_next,   req_now;
    logic [REQ_W-1:0]            call_bit,  car_bit;
    logic [ecc_pkg::FLOOR_W-1:0] up_floor,  down_floor;
    logic                        found_up,  found_down;

    // Latch the step's sensor report and floor call
    assign pos_now = (sensor_valid && (32'(sensor_floor) < FLOORS)) ? sensor_floor : pos_reg;

    always_comb begin
        for (int i = 0; i < REQ_W; i++) begin
            call_bit[i] = call_valid && (call_floor == ecc_pkg::FLOOR_W'(i));
            car_bit[i]  = (pos_now == ecc_pkg::FLOOR_W'(i));
        end
    end

    assign req_now = req_reg | call_bit;

    // Nearest request above the car, nearest request below the car
    always_comb begin
        found_up   = 1'b0;
        found_down = 1'b0;
        up_floor   = '0;
        down_floor = '0;
        for (int i = REQ_W - 1; i >= 0; i--) begin
            if (req_now[i] && (ecc_pkg::FLOOR_W'(i) > pos_now)) begin
                found_up = 1'b1;
                up_floor = ecc_pkg::FLOOR_W'(i);
            end
        end
        for (int i = 0; i < REQ_W; i++) begin
            if (req_now[i] && (ecc_pkg::FLOOR_W'(i) < pos_now)) begin
                found_down = 1'b1;
                down_floor = ecc_pkg::FLOOR_W'(i);
            end
        end
    end

    // Count a pending tick, saturating
    always_comb begin
        cnt_now = cnt_reg;
        if (tick_reg || half_second_tick) begin
            if (cnt_reg != ecc_pkg::COUNT_MAX) begin
                cnt_now = cnt_reg + 1'b1;
            end
        end
    end

    // Status seen by the controller
    assign status.estop      = estop_reg | estop;
    assign status.found_up   = found_up;
    assign status.found_down = found_down;
    assign status.near_up    = ({1'b0, dest_reg} == ({1'b0, pos_now} + 1'b1));
    assign status.near_down  = ({1'b0, pos_now} == ({1'b0, dest_reg} + 1'b1));
    assign status.at_target  = (pos_now == dest_reg);
    assign status.door_done  = (cnt_now >= cfg.door_ticks);

    // Apply the controller's commands on a step
    always_comb begin
        pos_next   = pos_reg;
        dest_next  = dest_reg;
        dir_next   = dir_reg;
        duty_next  = duty_reg;
        door_next  = door_reg;
        estop_next = estop_reg;
        tick_next  = tick_reg;
        cnt_next   = cnt_reg;
        req_next   = req_reg;
        if (step) begin
            pos_next   = pos_now;
            estop_next = estop_reg | estop;
            tick_next  = (tick_reg | half_second_tick) & ~cmd.tick_clr;

            unique case (cmd.duty_sel)
                ecc_pkg::DUTY_SEL_SLOW: duty_next = cfg.duty_slow;
                ecc_pkg::DUTY_SEL_FULL: duty_next = cfg.duty_full;
                default:                duty_next = cfg.duty_stop;
            endcase

            if (cmd.dir_load) begin
                dir_next = cmd.dir_val;
            end

            unique case (cmd.dest_op)
                ecc_pkg::DEST_UP:   dest_next = up_floor;
                ecc_pkg::DEST_DOWN: dest_next = down_floor;
                default:            dest_next = dest_reg;
            endcase

            unique case (cmd.req_op)
                ecc_pkg::REQ_CLEAR_ALL: req_next = '0;
                ecc_pkg::REQ_CLEAR_CAR: req_next = req_now & ~car_bit;
                default:                req_next = req_now;
            endcase

            unique case (cmd.door_op)
                ecc_pkg::DOOR_SET:   door_next = 1'b1;
                ecc_pkg::DOOR_CLOSE: door_next = 1'b0;
                default:             door_next = door_reg;
            endcase

            unique case (cmd.cnt_op)
                ecc_pkg::CNT_CLEAR: cnt_next = '0;
                ecc_pkg::CNT_COUNT: cnt_next = cnt_now;
                default:            cnt_next = cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            dest_reg  <= '0;
            dir_reg   <= ecc_pkg::DIR_NONE;
            duty_reg  <= '0;
            door_reg  <= 1'b0;
            estop_reg <= 1'b0;
            tick_reg  <= 1'b0;
            cnt_reg   <= '0;
            req_reg   <= '0;
        end else begin
            pos_reg   <= pos_next;
            dest_reg  <= dest_next;
            dir_reg   <= dir_next;
            duty_reg  <= duty_next;
            door_reg  <= door_next;
            estop_reg <= estop_next;
            tick_reg  <= tick_next;
            cnt_reg   <= cnt_next;
            req_reg   <= req_next;
        end
    end

    assign direction    = dir_reg;
    assign duty         = duty_reg;
    assign doors_open   = door_reg;
    assign target_floor = dest_reg;
    assign cabin_floor  = pos_reg;
    assign pending_mask = ecc_pkg::MASK_W'(req_reg);

endmodule

`default_nettype wire

[src/elevator_car_controller_core.sv]
// ----------------------------------------------------------------------------
// elevator_car_controller_core: elevator car controller
// Each input request is one update step: its sensor, call, emergency stop
// and tick events are latched, then the mode machine runs once and one
// result request carries the car state after the step.
//
// Input channel s_*: valid/ready; one request per update step.
// Result channel m_*: valid/ready; exactly one result per input request,
//   shown from the cycle after the input is accepted.
// Throughput: one step per cycle unless the receiver stalls. The whole step is
//   the mode machine and a search over at most eight request bits.
// A new input is taken while the previous result is being taken; while the
//   receiver stalls, the result holds and s_ready stays low.
// Configuration: APB-style port, registers duty_full, duty_slow, duty_stop,
//   door_ticks at byte addresses 0, 4, 8, 12; zero wait states.
// Reset (aresetn low, synchronous): car idle at floor 0, no requests,
//   emergency latch clear, registers at their reset values, no result held.
// The emergency latch is cleared only by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_car_controller_core #(
    parameter int FLOORS = ecc_pkg::FLOORS_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ecc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ecc_pkg::DATA_W-1:0]   pwdata,
    output logic      [ecc_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    // Input channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_sensor_valid,
    input  wire logic [ecc_pkg::FLOOR_W-1:0]  s_sensor_floor,
    input  wire logic                         s_call_valid,
    input  wire logic [ecc_pkg::FLOOR_W-1:0]  s_call_floor,
    input  wire logic                         s_estop,
    input  wire logic                         s_half_second_tick,
    // Result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [ecc_pkg::MODE_W-1:0]   m_mode,
    output logic      [ecc_pkg::DIR_W-1:0]    m_direction,
    output logic      [ecc_pkg::DUTY_W-1:0]   m_duty,
    output logic                              m_doors_open,
    output logic      [ecc_pkg::FLOOR_W-1:0]  m_target_floor,
    output logic      [ecc_pkg::FLOOR_W-1:0]  m_cabin_floor,
    output logic      [ecc_pkg::MASK_W-1:0]   m_pending_mask
);

    ecc_pkg::cfg_t    cfg;
    ecc_pkg::cmd_t    cmd;
    ecc_pkg::status_t status;
    logic             step;
    logic             m_valid_reg;
    logic             m_valid_next;

    // Take a request when the result slot is free or being emptied
    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    // Hold the result until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    ecc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ecc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .status  (status),
        .cmd     (cmd),
        .mode    (m_mode)
    );

    ecc_dpath #(
        .FLOORS (FLOORS)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (step),
        .sensor_valid     (s_sensor_valid),
        .sensor_floor     (s_sensor_floor),
        .call_valid       (s_call_valid),
        .call_floor       (s_call_floor),
        .estop            (s_estop),
        .half_second_tick (s_half_second_tick),
        .cfg              (cfg),
        .cmd              (cmd),
        .status           (status),
        .direction        (m_direction),
        .duty             (m_duty),
        .doors_open       (m_doors_open),
        .target_floor     (m_target_floor),
        .cabin_floor      (m_cabin_floor),
        .pending_mask     (m_pending_mask)
    );

    // An emergency stop puts the car in emergency mode at once
    a_estop_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && s_estop) |=> (m_mode == ecc_pkg::MODE_EMERG))
        else $error("emergency stop did not force emergency mode");

    // Doors are open exactly in the doors-open mode
    a_doors_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_doors_open == (m_mode == ecc_pkg::MODE_DOORS))
        else $error("door flag disagrees with car mode");

    // Emergency mode holds no requests and no direction
    a_emerg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_mode == ecc_pkg::MODE_EMERG) |->
            ((m_pending_mask == '0) && (m_direction == ecc_pkg::DIR_NONE)))
        else $error("requests or direction left in emergency mode");

    // A step outside emergency while moving up keeps the mode or opens the doors
    a_move_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !s_estop && (m_mode == ecc_pkg::MODE_UP)) |=>
            ((m_mode == ecc_pkg::MODE_UP) || (m_mode == ecc_pkg::MODE_DOORS) ||
             (m_mode == ecc_pkg::MODE_EMERG)))
        else $error("illegal mode change while moving up");

endmodule

`default_nettype wire
